### sv/four_level_page_table_mapper_core_macros.svh
// Assertion helpers for the page table mapper.
// Each macro expects clk and arst_n in scope.
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_CORE_MACROS_SVH

// same-cycle implication
`define FLTM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FLTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/fltm_pkg.sv
package fltm_pkg;

	localparam int ENTRY_W = 64;
	localparam int PAGE_W  = 36;
	localparam int CNT_W   = 7;
	localparam int FRESH_W = 2;
	localparam int LIMIT_W = 7;

	// entry flag positions
	localparam int BIT_PRESENT = 0;
	localparam int BIT_RW      = 1;
	localparam int BIT_USER    = 2;
	localparam int BIT_NX      = 63;

	// present | rw | user for upper-level pointers
	localparam logic [2:0] UPPER_FLAGS = 3'b111;

	// config register indexes
	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	// result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_ABORT = 1'b1;

	localparam logic [PAGE_W-1:0]  BASE_RESET  = 36'd1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

endpackage

### sv/fltm_store.sv
module fltm_store #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [fltm_pkg::ENTRY_W-1:0]   wdata,
	input  logic [AW-1:0]                  raddr,
	output logic [fltm_pkg::ENTRY_W-1:0]   rdata
);

	logic [fltm_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/four_level_page_table_mapper_core.sv
// Four-level page table mapper.
// Input channel (in_valid/in_ready) takes one request beat: page_number,
// writeable, executable. The block walks root, pointer and directory levels
// of the table store, allocating zeroed table pages from a bump counter where
// an entry is missing, then writes the leaf entry.
// Output channel (out_valid/out_ready) returns one beat per request: status,
// leaf_entry (zero on abort), new_tables, pages_in_use.
// Config port: cfg_write with cfg_index/cfg_data, no wait; index 0 is the
// table base page, index 1 the page limit. Write only while idle.
// Walk: the store read is registered, so each of the three upper levels is
// a read step and then an evaluate step; the root read is issued in the
// accept cycle. The leaf write and the result handoff share the final
// step. An abort shortens the walk.
// Reset: the store is swept to zero, one entry per cycle, over all
// TABLE_PAGES*ENTRIES_PER_TABLE entries (32768 at defaults); in_ready
// stays low meanwhile.
// Stall: the result sits in the output register; the block still accepts and
// walks the next request, and holds in its final step until the slot frees.
module four_level_page_table_mapper_core #(
	parameter int TABLE_PAGES       = 64,
	parameter int ENTRIES_PER_TABLE = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fltm_pkg::PAGE_W-1:0]       page_number,
	input  logic                              writeable,
	input  logic                              executable,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              status,
	output logic [fltm_pkg::ENTRY_W-1:0]      leaf_entry,
	output logic [fltm_pkg::FRESH_W-1:0]      new_tables,
	output logic [fltm_pkg::CNT_W-1:0]        pages_in_use,
	input  logic                              cfg_write,
	input  logic                              cfg_index,
	input  logic [fltm_pkg::PAGE_W-1:0]       cfg_data
);

	localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);
	localparam int PGW   = $clog2(TABLE_PAGES);
	localparam int AW    = PGW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
	localparam int PW    = fltm_pkg::PAGE_W;
	localparam int EW    = fltm_pkg::ENTRY_W;
	localparam int CW    = fltm_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_READ,
		ST_FIN
	} state_t;

	state_t state_q;

	// config
	logic [PW-1:0]                base_q;
	logic [fltm_pkg::LIMIT_W-1:0] limit_q;

	// walk context
	logic [AW-1:0]                clr_q;
	logic [PW-1:0]                pn_q;
	logic                         wr_q;
	logic                         ex_q;
	logic [1:0]                   lvl_q;
	logic [PGW-1:0]               page_q;
	logic [fltm_pkg::FRESH_W-1:0] fresh_q;
	logic                         ok_q;
	logic [CW-1:0]                pa_q;

	// output slot
	logic                         out_valid_q;
	logic                         status_q;
	logic [EW-1:0]                leaf_q;
	logic [fltm_pkg::FRESH_W-1:0] fresh_out_q;
	logic [CW-1:0]                used_q;

	// store port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;

	logic [IDX_W-1:0] idx_sel;
	logic [AW-1:0]    cur_addr;
	logic [EW-1:0]    leaf_val;
	logic [8:0]       lim_eff;
	logic [8:0]       pa_ext;
	logic             alloc_ok;
	logic             present;
	logic [PW-1:0]    off;
	logic             hit_ok;
	logic [PW-1:0]    alloc_phys;
	logic [EW-1:0]    ptr_entry;
	logic             out_free;

	//------------------------------------------------------------------
	// Config registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= fltm_pkg::BASE_RESET;
			limit_q <= fltm_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fltm_pkg::CFG_BASE:  base_q  <= cfg_data;
				fltm_pkg::CFG_LIMIT: limit_q <= cfg_data[fltm_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Walk datapath
	//------------------------------------------------------------------
	// Level 0..2 pick the upper indices, level 3 the leaf index.
	always_comb begin
		case (lvl_q)
			2'd0:    idx_sel = pn_q[3*IDX_W +: IDX_W];
			2'd1:    idx_sel = pn_q[2*IDX_W +: IDX_W];
			2'd2:    idx_sel = pn_q[IDX_W +: IDX_W];
			default: idx_sel = pn_q[IDX_W-1:0];
		endcase
	end

	assign cur_addr = {page_q, idx_sel};

	// Root read is issued in the accept cycle straight from the port.
	assign mem_raddr = (state_q == ST_IDLE) ?
		{{PGW{1'b0}}, page_number[3*IDX_W +: IDX_W]} : cur_addr;

	// Leaf: NX | page << 12 | user | rw | present
	assign leaf_val = {!ex_q, {(EW-PW-13){1'b0}}, pn_q, 9'd0, 1'b1, wr_q, 1'b1};

	// Effective limit is capped at the region size.
	assign lim_eff  = (9'(limit_q) > 9'(TABLE_PAGES)) ? 9'(TABLE_PAGES) : 9'(limit_q);
	assign pa_ext   = {2'b00, pa_q};
	assign alloc_ok = (pa_ext + 9'd1) < lim_eff;

	// Present pointer must resolve to an allocated region page under the
	// current base; anything else is stale and aborts.
	assign present = mem_rdata[fltm_pkg::BIT_PRESENT];
	assign off     = mem_rdata[PW+11:12] - base_q;
	assign hit_ok  = off < {{(PW-CW){1'b0}}, pa_q};

	// New table lives at base + pa (wraps at 36 bits).
	assign alloc_phys = base_q + {{(PW-CW){1'b0}}, pa_q};
	assign ptr_entry  = {{(EW-PW-12){1'b0}}, alloc_phys, 9'd0, fltm_pkg::UPPER_FLAGS};

	assign out_free = !out_valid_q || out_ready;

	// Single write port: clear sweep, pointer fill, leaf write.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = leaf_val;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_EVAL: begin
				mem_we    = !present && alloc_ok;
				mem_wdata = ptr_entry;
			end
			ST_FIN: begin
				mem_we = ok_q && out_free;
			end
			default: ;
		endcase
	end

	fltm_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	//------------------------------------------------------------------
	// Sequencer and output slot
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pn_q        <= '0;
			wr_q        <= 1'b0;
			ex_q        <= 1'b0;
			lvl_q       <= '0;
			page_q      <= '0;
			fresh_q     <= '0;
			ok_q        <= 1'b1;
			pa_q        <= CW'(1);
			out_valid_q <= 1'b0;
			status_q    <= fltm_pkg::STATUS_OK;
			leaf_q      <= '0;
			fresh_out_q <= '0;
			used_q      <= '0;
		end else begin
			// slot loads in the final step, drains on a taken beat
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						pn_q    <= page_number;
						wr_q    <= writeable;
						ex_q    <= executable;
						lvl_q   <= '0;
						page_q  <= '0;
						fresh_q <= '0;
						ok_q    <= 1'b1;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if ((!present && !alloc_ok) || (present && !hit_ok)) begin
						ok_q    <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						if (!present) begin
							pa_q    <= pa_q + CW'(1);
							fresh_q <= fresh_q + 2'd1;
							page_q  <= pa_ext[PGW-1:0];
						end else begin
							page_q  <= off[PGW-1:0];
						end
						lvl_q <= lvl_q + 2'd1;
						if (lvl_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_FIN: begin
					if (out_free) begin
						status_q    <= ok_q ? fltm_pkg::STATUS_OK : fltm_pkg::STATUS_ABORT;
						leaf_q      <= ok_q ? leaf_val : '0;
						fresh_out_q <= fresh_q;
						used_q      <= pa_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign leaf_entry   = leaf_q;
	assign new_tables   = fresh_out_q;
	assign pages_in_use = used_q;

	//------------------------------------------------------------------
	// Checks
	//------------------------------------------------------------------
`include "four_level_page_table_mapper_core_macros.svh"

	`FLTM_ASSERT_NOW(a_no_write_idle, (state_q == ST_IDLE), !mem_we, "store written while idle")
	`FLTM_ASSERT_NEXT(a_pa_only_eval, (state_q != ST_EVAL), $stable(pa_q), "page count moved outside evaluate")
	`FLTM_ASSERT_NOW(a_abort_zero_leaf, (out_valid && status == fltm_pkg::STATUS_ABORT), (leaf_entry == '0), "abort with nonzero leaf")
	`FLTM_ASSERT_NOW(a_pa_in_region, 1'b1, ({2'b00, pa_q} < 9'(TABLE_PAGES)), "page count beyond region")

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int PT_PAGES   = 64;
	localparam int PT_ENTRIES = 512;
	// cap covers the clear sweep after reset with a wide margin
	localparam int unsigned CYCLE_CAP = 400000;
	localparam int unsigned ERR_PRINT_MAX = 100;

	// one request beat
	typedef struct packed {
		logic [fltm_pkg::PAGE_W-1:0] pn;
		logic                        wr;
		logic                        ex;
	} map_req_t;

	// one result beat
	typedef struct packed {
		logic                         status;
		logic [fltm_pkg::ENTRY_W-1:0] leaf;
		logic [fltm_pkg::FRESH_W-1:0] fresh;
		logic [fltm_pkg::CNT_W-1:0]   in_use;
	} map_result_t;

	typedef enum logic [1:0] {RCV_FREE, RCV_LIGHT, RCV_HEAVY, RCV_TRICKLE} rcv_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [fltm_pkg::PAGE_W-1:0]   page_number = '0;
	logic                          writeable = 1'b0;
	logic                          executable = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          status;
	logic [fltm_pkg::ENTRY_W-1:0]  leaf_entry;
	logic [fltm_pkg::FRESH_W-1:0]  new_tables;
	logic [fltm_pkg::CNT_W-1:0]    pages_in_use;
	logic                          cfg_write = 1'b0;
	logic                          cfg_index = 1'b0;
	logic [fltm_pkg::PAGE_W-1:0]   cfg_data = '0;

	// shadow copy of the block's table store and allocator
	logic [fltm_pkg::ENTRY_W-1:0]  pt_store [PT_PAGES*PT_ENTRIES];
	int unsigned                   pages_used = 1;
	logic [fltm_pkg::PAGE_W-1:0]   base_page = fltm_pkg::BASE_RESET;
	logic [fltm_pkg::LIMIT_W-1:0]  page_limit = fltm_pkg::LIMIT_RESET;

	map_req_t            map_reqs [$];   // waiting to be driven
	map_result_t         map_exp [$];    // predicted result beats, oldest first
	logic [26:0]         prefixes [$];   // upper 27 bits of pages sent so far

	map_req_t            drv_req;
	map_result_t         got_res, want_res;
	logic                acc_q = 1'b0;
	int unsigned         burst_left = 1, gap_left = 0;
	int unsigned         rcv_tick = 0;
	rcv_mode_t           rcv_mode = RCV_FREE;
	int unsigned         cycles = 0;
	int unsigned         mismatches = 0;
	int unsigned         n_req = 0, n_ok = 0, n_abort = 0, n_alloc = 0, n_cfg = 0;

	four_level_page_table_mapper_core #(
		.TABLE_PAGES      (PT_PAGES),
		.ENTRIES_PER_TABLE(PT_ENTRIES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.page_number (page_number),
		.writeable   (writeable),
		.executable  (executable),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.leaf_entry  (leaf_entry),
		.new_tables  (new_tables),
		.pages_in_use(pages_in_use),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// Walk root, pointer and directory levels of the shadow store for one
	// request, allocating where an entry is missing, then write the leaf.
	function automatic map_result_t map_page(input logic [fltm_pkg::PAGE_W-1:0] pn,
			input logic wr, input logic ex);
		map_result_t                  res;
		logic [8:0]                   lvl_idx [4];
		logic [fltm_pkg::ENTRY_W-1:0] ent;
		logic [fltm_pkg::PAGE_W-1:0]  phys, offs;
		int unsigned                  cur_pg, nxt_pg, slot, cap, n_fresh;
		logic                         ok;
		lvl_idx[0] = pn[35:27];
		lvl_idx[1] = pn[26:18];
		lvl_idx[2] = pn[17:9];
		lvl_idx[3] = pn[8:0];
		res = '0;
		cur_pg = 0;
		n_fresh = 0;
		ok = 1'b1;
		// limit register is capped at the region size
		cap = (page_limit > PT_PAGES) ? PT_PAGES : page_limit;
		for (int lvl = 0; lvl < 3 && ok; lvl++) begin
			slot = cur_pg * PT_ENTRIES + lvl_idx[lvl];
			ent = pt_store[slot];
			if (!ent[fltm_pkg::BIT_PRESENT]) begin
				// out of table space: abandon, earlier levels stay written
				if (pages_used + 1 >= cap) begin
					ok = 1'b0;
				end else begin
					nxt_pg = pages_used;
					pages_used++;
					for (int i = 0; i < PT_ENTRIES; i++)
						pt_store[nxt_pg * PT_ENTRIES + i] = '0;
					n_fresh++;
					// table physical page wraps modulo 2^36
					phys = base_page + fltm_pkg::PAGE_W'(nxt_pg);
					pt_store[slot] = {16'b0, phys, 9'b0, fltm_pkg::UPPER_FLAGS};
					cur_pg = nxt_pg;
				end
			end else begin
				// pointer must name an allocated region page under the current base
				offs = ent[47:12] - base_page;
				if (offs >= pages_used || offs >= PT_PAGES)
					ok = 1'b0;
				else
					cur_pg = 32'(offs);
			end
		end
		if (ok) begin
			res.leaf = {16'b0, pn, 12'b0};
			res.leaf[fltm_pkg::BIT_PRESENT] = 1'b1;
			res.leaf[fltm_pkg::BIT_USER] = 1'b1;
			res.leaf[fltm_pkg::BIT_RW] = wr;
			res.leaf[fltm_pkg::BIT_NX] = ~ex;
			pt_store[cur_pg * PT_ENTRIES + lvl_idx[3]] = res.leaf;
		end
		res.status = ok ? fltm_pkg::STATUS_OK : fltm_pkg::STATUS_ABORT;
		res.fresh = fltm_pkg::FRESH_W'(n_fresh);
		res.in_use = fltm_pkg::CNT_W'(pages_used);
		n_alloc += n_fresh;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			// keep the log readable when the block is badly off
			if (mismatches <= ERR_PRINT_MAX)
				$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
		end
	endfunction

	// Register write: one cycle of cfg_write, shadow updated alongside.
	task automatic set_reg(input logic idx, input logic [fltm_pkg::PAGE_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == fltm_pkg::CFG_BASE)
			base_page = val;
		else
			page_limit = val[fltm_pkg::LIMIT_W-1:0];
		n_cfg++;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic push_req(input logic [fltm_pkg::PAGE_W-1:0] pn, input logic wr,
			input logic ex);
		map_req_t r;
		r.pn = pn;
		r.wr = wr;
		r.ex = ex;
		map_reqs.push_back(r);
		prefixes.push_back(pn[35:9]);
	endtask

	// Random request, mostly under tables already built so walks get to the leaf.
	task automatic push_rand_req();
		logic [63:0] rnd;
		logic [26:0] pfx;
		int unsigned pick;
		logic [fltm_pkg::PAGE_W-1:0] pn;
		rnd = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (prefixes.size() == 0 || pick < 10) begin
			pn = rnd[fltm_pkg::PAGE_W-1:0];                // fresh root slot, likely
		end else begin
			pfx = prefixes[$urandom_range(0, prefixes.size() - 1)];
			if (pick < 70)
				pn = {pfx, rnd[8:0]};                      // same directory table
			else if (pick < 82)
				pn = {pfx[26:9], rnd[17:0]};               // new directory entry
			else if (pick < 92)
				pn = {pfx[26:18], rnd[26:0]};              // new pointer entry
			else
				pn = {pfx, (rnd[9] ? 9'h1FF : 9'h000)};    // leaf index extremes
		end
		push_req(pn, rnd[40], rnd[41]);
	endtask

	// Idle point: nothing queued, nothing in flight, then a short pause.
	task automatic settle();
		while (map_reqs.size() != 0 || in_valid || map_exp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Sender: bursts of beats with random gaps; valid holds until taken.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !acc_q)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (map_reqs.size() > 0) begin
				drv_req = map_reqs.pop_front();
				page_number <= drv_req.pn;
				writeable <= drv_req.wr;
				executable <= drv_req.ex;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 20);
					// about a third of the bursts run back to back
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern drawn at random from free, light, heavy and trickle modes.
	always @(negedge clk) begin
		rcv_tick++;
		if (rcv_tick % 48 == 0)
			rcv_mode = rcv_mode_t'($urandom_range(0, 3));
		case (rcv_mode)
			RCV_FREE: begin
				out_ready <= 1'b1;
			end
			RCV_LIGHT: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			RCV_HEAVY: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				out_ready <= (rcv_tick[2:0] == 3'd0);
			end
		endcase
	end

	// Monitor: check result beats, predict on accepted request beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
		end else begin
			acc_q <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (map_exp.size() == 0) begin
					mismatches++;
					$error("result beat with no request outstanding");
				end else begin
					want_res = map_exp.pop_front();
					check_field("status", want_res.status, status);
					check_field("leaf_entry", want_res.leaf, leaf_entry);
					check_field("new_tables", want_res.fresh, new_tables);
					check_field("pages_in_use", want_res.in_use, pages_in_use);
				end
			end
			if (in_valid && in_ready) begin
				got_res = map_page(page_number, writeable, executable);
				map_exp.push_back(got_res);
				n_req++;
				if (got_res.status == fltm_pkg::STATUS_OK)
					n_ok++;
				else
					n_abort++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, map_exp.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < PT_PAGES * PT_ENTRIES; i++)
			pt_store[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Base near the top so table pages wrap past zero; tight limit so the
		// second new root slot runs out partway through its walk.
		set_reg(fltm_pkg::CFG_BASE, 36'hFFFFFFFFE);
		set_reg(fltm_pkg::CFG_LIMIT, 36'd6);
		push_req(36'h000000000, 1'b1, 1'b1);   // three fresh tables
		push_req(36'h000000001, 1'b0, 1'b0);   // same tables, NX leaf
		push_req(36'h000000000, 1'b0, 1'b1);   // overwrite existing leaf
		push_req(36'hFFFFFFFFF, 1'b1, 1'b0);   // one table then out of space
		push_req(36'hFFFFFFFFF, 1'b1, 1'b1);   // fails at pointer level
		push_req(36'h000000200, 1'b0, 1'b1);   // fails at directory level
		settle();

		// limit zero and limit two: any allocation fails, existing walks pass
		set_reg(fltm_pkg::CFG_LIMIT, 36'd0);
		push_req(36'h0000001FF, 1'b1, 1'b1);
		push_req(36'h800000000, 1'b0, 1'b0);
		settle();
		set_reg(fltm_pkg::CFG_LIMIT, 36'd2);
		push_req(36'h000000400, 1'b1, 1'b0);
		push_req(36'h000000002, 1'b1, 1'b0);
		settle();

		// limit above region size is capped
		set_reg(fltm_pkg::CFG_LIMIT, 36'd127);
		push_req(36'hFFFFFFFFF, 1'b0, 1'b1);   // finishes the abandoned walk
		push_req(36'h5A5A5A5A5, 1'b1, 1'b0);
		settle();

		// moved base: old pointers go stale or alias other region pages
		set_reg(fltm_pkg::CFG_BASE, 36'h000000000);
		push_req(36'h000000000, 1'b1, 1'b1);
		push_req(36'h5A5A5A5A5, 1'b0, 1'b1);
		push_req(36'h123456789, 1'b1, 1'b0);
		push_req(36'hAAAAAAAAA, 1'b0, 1'b0);
		push_req(36'h555555555, 1'b1, 1'b1);
		settle();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					set_reg(fltm_pkg::CFG_LIMIT, 36'd64);
				end
				1: begin
					set_reg(fltm_pkg::CFG_LIMIT, fltm_pkg::PAGE_W'($urandom_range(2, 64)));
				end
				2: begin
					set_reg(fltm_pkg::CFG_BASE, 36'h000000001);
					set_reg(fltm_pkg::CFG_LIMIT, 36'd127);
				end
				default: begin
					set_reg(fltm_pkg::CFG_BASE, 36'h000000000);
					set_reg(fltm_pkg::CFG_LIMIT, 36'd64);
				end
			endcase
			repeat ((ph == 0 || ph == 3) ? 165 : 110)
				push_rand_req();
			settle();
		end

		repeat (12) @(posedge clk);
		$display("covered %0d requests (%0d mapped, %0d abandoned), %0d table pages allocated,",
			n_req, n_ok, n_abort, n_alloc);
		$display("%0d register writes, wrapped and moved table base, bursty sender, stalling sink",
			n_cfg);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/fltm_pkg.sv
sv/fltm_store.sv
sv/four_level_page_table_mapper_core.sv
verif/tb_top.sv
